>>> rtl/core/bdq_pkg.sv
package bdq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned STATUS_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_ALL   = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_READ
  } ctrl_state_e;

  typedef enum logic [1:0] {
    SEL_OK,
    SEL_EMPTY,
    SEL_FULL,
    SEL_RAM
  } out_sel_e;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic [STATUS_W-1:0]       status;
    logic                      last;
  } out_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic     push_front;
    logic     push_back;
    logic     pop_front;
    logic     pop_back;
    logic     rd_start;
    logic     rd_next;
    logic     out_load;
    out_sel_e out_sel;
    logic     out_last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic rd_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/bdq_ram.sv
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bdq_datapath.sv
module bdq_datapath import bdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_req_t  in_req_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             out_valid_q, out_valid_d;
  out_rsp_t         out_q, out_d;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;
  logic [IDX_W-1:0] front_dec, front_inc, rd_idx_inc;
  logic             out_free;

  // circular slot of an offset from the front; sum stays below 2*DEPTH
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign front_dec  = (front_q == '0) ? LAST_IDX : front_q - IDX_W'(1);
  assign front_inc  = (front_q == LAST_IDX) ? '0 : front_q + IDX_W'(1);
  assign rd_idx_inc = rd_idx_q + IDX_W'(1);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    ram_we    = cmd_i.push_front || cmd_i.push_back;
    ram_waddr = cmd_i.push_front ? front_dec : slot_of(front_q, count_q[IDX_W-1:0]);
    ram_re    = cmd_i.pop_front || cmd_i.pop_back || cmd_i.rd_start || cmd_i.rd_next;
    priority if (cmd_i.pop_back) begin
      ram_raddr = slot_of(front_q, IDX_W'(count_q - CNT_W'(1)));
    end else if (cmd_i.rd_next) begin
      ram_raddr = slot_of(front_q, rd_idx_inc);
    end else begin
      ram_raddr = front_q;
    end
  end

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.push_front) begin
      front_d = front_dec;
    end
    if (cmd_i.pop_front) begin
      front_d = front_inc;
    end
    if (cmd_i.push_front || cmd_i.push_back) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.pop_front || cmd_i.pop_back) begin
      count_d = count_q - CNT_W'(1);
    end
    if (cmd_i.rd_start) begin
      rd_idx_d = '0;
    end
    if (cmd_i.rd_next) begin
      rd_idx_d = rd_idx_inc;
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d    = 1'b1;
      out_d.last     = cmd_i.out_last;
      out_d.value_res = '0;
      unique case (cmd_i.out_sel)
        SEL_OK: begin
          out_d.status = STAT_OK;
        end
        SEL_EMPTY: begin
          out_d.status = STAT_EMPTY;
        end
        SEL_FULL: begin
          out_d.status = STAT_FULL;
        end
        SEL_RAM: begin
          out_d.status    = STAT_OK;
          out_d.value_res = ram_rdata;
        end
        default: begin
          out_d.status = STAT_OK;
        end
      endcase
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  bdq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_req_i.value),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign stat_o.full     = (count_q == CNT_FULL);
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.rd_last  = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q);
  assign stat_o.out_free = out_free;
  assign out_valid_o     = out_valid_q;
  assign out_rsp_o       = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL) else $error("element count above depth");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= LAST_IDX) else $error("front index out of range");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re)) else $error("store written and read in one cycle");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop_front || cmd_i.pop_back) |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("pop did not drop the count by one");

endmodule

>>> rtl/core/bdq_ctrl.sv
module bdq_ctrl import bdq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CMD_W-1:0] cmd_i,
  input  dp_stat_t         stat_i,
  output dp_cmd_t          cmd_o
);

  ctrl_state_e state_q, state_d;
  cmd_e        cmd;

  assign cmd = cmd_e'(cmd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !stat_i.out_free;
        if (in_valid_i && stat_i.out_free) begin
          unique case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_sel = SEL_FULL;
              end else begin
                cmd_o.out_sel    = SEL_OK;
                cmd_o.push_front = (cmd == CMD_PUSH_FRONT);
                cmd_o.push_back  = (cmd == CMD_PUSH_BACK);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (stat_i.empty) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_last = 1'b1;
                cmd_o.out_sel  = SEL_EMPTY;
              end else begin
                cmd_o.pop_front = (cmd == CMD_POP_FRONT);
                cmd_o.pop_back  = (cmd == CMD_POP_BACK);
                state_d         = ST_POP;
              end
            end
            CMD_READ_ALL: begin
              if (stat_i.empty) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_last = 1'b1;
                cmd_o.out_sel  = SEL_EMPTY;
              end else begin
                cmd_o.rd_start = 1'b1;
                state_d        = ST_READ;
              end
            end
            default: begin
              // unused codes are dropped without a result
            end
          endcase
        end
      end
      ST_POP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.out_sel  = SEL_RAM;
          state_d        = ST_IDLE;
        end
      end
      ST_READ: begin
        // the next read is issued as the current word goes out
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_RAM;
          cmd_o.out_last = stat_i.rd_last;
          if (stat_i.rd_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("request taken while busy");

  a_pop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP && stat_i.out_free) |=> state_q == ST_IDLE)
    else $error("pop result not closed out");

  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_last && state_q == ST_READ) |=> state_q == ST_IDLE)
    else $error("read-out continued past last element");

endmodule

>>> rtl/core/bounded_deque_with_readout.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o  | in_req_i  (cmd, value)
// out     | output    | out_valid_o / out_stall_i | out_rsp_o (value_res, status, last)
//
// Push, and any command that hits a full or empty queue, loads its result into the output register directly.
// Pop reads the store, then loads the output register from ST_POP once the output is free.
// Read-out uses the store's single read port, one element per cycle unless the output stalls.
// Reset clears front index, count and output valid; store contents are undefined until written.
// A request is taken only in idle while the output register is empty or draining;
// a stall on the output holds the controller in place.
module bounded_deque_with_readout import bdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  bdq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .cmd_i     (in_req_i.cmd),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd)
  );

  bdq_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_rsp_o  (out_rsp_o)
  );

endmodule
